FILE: rtl/core/pppg_pkg.sv
// Package for the parametric path point generator.
// Shared types, register codes, widths and the sine table builder.
// No dependencies.
package pppg_pkg;

  localparam int QDEPTH  = 4;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int T_W     = 29;   // progress t, Q0.28 plus the value one
  localparam int SIN_W   = 13;   // table entries 0..4096
  localparam int COORD_W = 17;
  localparam int NORM_W  = 16;
  localparam int PROG_W  = 17;
  localparam int DIV_LAT = NORM_W + 1;
  localparam int PINGPONG_BIT = 3;
  localparam logic [15:0] MIN_SIZE = 16'd4;

  typedef enum logic [2:0] {
    SHAPE_CIRCLE = 3'd0,
    SHAPE_LINE   = 3'd1,
    SHAPE_FIG8   = 3'd2,
    SHAPE_HELIX  = 3'd3,
    SHAPE_SPIRAL = 3'd4,
    SHAPE_LISSA  = 3'd5
  } shape_e;

  typedef enum logic [2:0] {
    REG_SPEED  = 3'd0,
    REG_PHASE  = 3'd1,
    REG_MODE   = 3'd2,
    REG_SIZE_X = 3'd3,
    REG_SIZE_Y = 3'd4,
    REG_SIZE_Z = 3'd5,
    REG_TURNS  = 3'd6,
    REG_RATIO  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] phase;
    logic [3:0]  mode;
    logic [15:0] size_x;
    logic [15:0] size_y;
    logic [15:0] size_z;
    logic [15:0] turns;
    logic [15:0] ratio;
  } cfg_t;

  typedef struct packed {
    logic [T_W-1:0] t;
    shape_e         shape;
  } qword_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [PROG_W-1:0]         prog;
  } coord_t;

  // Quarter-wave sine entry, Q30 Taylor series, rounded to Q1.12.
  function automatic logic [SIN_W-1:0] sine_entry(input int unsigned idx,
                                                  input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] e;
    x    = (64'd1686629713 * 64'(idx)) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) sum = sum - $signed(term);
      else              sum = sum + $signed(term);
    end
    if (sum < 0) sum = '0;
    e = (sum + 64'sd131072) >>> 18;
    if (e > 64'sd4096) e = 64'sd4096;
    return e[SIN_W-1:0];
  endfunction

endpackage

FILE: rtl/core/parametric_path_point_generator.sv
// Top level of the parametric path point generator: register bank and the
// front end, queue and back end. Depends on pppg_pkg, pppg_front, pppg_fifo, pppg_back.
//
//   port group   dir  handshake              word
//   in_*         in   in_valid_i/in_ready_o  beat_time_i
//   out_*        out  out_valid_o/out_ready_i point_x/y/z, progress, norm_x/y/z
//   cfg_*        in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled; a result passes
// the front register (loaded on the accepting edge), the queue and 23 back
// stages, 17 of them the normalizing dividers.
// The front and back stall independently across a 4-entry queue; a stalled
// output freezes the whole back pipeline. Reset restores the register
// defaults; the config port is always ready.
module parametric_path_point_generator
  import pppg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [31:0]               beat_time_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] point_x_o,
  output logic signed [COORD_W-1:0] point_y_o,
  output logic signed [COORD_W-1:0] point_z_o,
  output logic [PROG_W-1:0]         progress_o,
  output logic [NORM_W-1:0]         norm_x_o,
  output logic [NORM_W-1:0]         norm_y_o,
  output logic [NORM_W-1:0]         norm_z_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [7:0]                cfg_index_i,
  input  logic [15:0]               cfg_data_i
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_index_i[7:3] == 5'd0) begin
      unique case (cfg_reg_e'(cfg_index_i[2:0]))
        REG_SPEED:  cfg_d.speed  = cfg_data_i;
        REG_PHASE:  cfg_d.phase  = cfg_data_i;
        REG_MODE:   cfg_d.mode   = cfg_data_i[3:0];
        REG_SIZE_X: cfg_d.size_x = cfg_data_i;
        REG_SIZE_Y: cfg_d.size_y = cfg_data_i;
        REG_SIZE_Z: cfg_d.size_z = cfg_data_i;
        REG_TURNS:  cfg_d.turns  = cfg_data_i;
        REG_RATIO:  cfg_d.ratio  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed  <= 16'd4096;
      cfg_q.phase  <= 16'd0;
      cfg_q.mode   <= 4'd0;
      cfg_q.size_x <= 16'd4096;
      cfg_q.size_y <= 16'd4096;
      cfg_q.size_z <= 16'd4096;
      cfg_q.turns  <= 16'd12288;
      cfg_q.ratio  <= 16'd770;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic              push;
  qword_t            push_data;
  logic              pop;
  logic              q_valid;
  qword_t            q_data;
  logic [QCNT_W-1:0] q_count;

  pppg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .beat_time_i (beat_time_i),
    .cfg_i       (cfg_q),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  pppg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  pppg_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_z_o   (point_z_o),
    .progress_o  (progress_o),
    .norm_x_o    (norm_x_o),
    .norm_y_o    (norm_y_o),
    .norm_z_o    (norm_z_o)
  );

endmodule

FILE: rtl/core/pppg_front.sv
// Front end: accepts beat words, forms the wrapped (or, in ping-pong mode, folded) progress t and the shape.
// Depends on pppg_pkg; pushes into pppg_fifo.
module pppg_front
  import pppg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       beat_time_i,
  input  cfg_t              cfg_i,
  input  logic [QCNT_W-1:0] q_count_i,
  output logic              push_o,
  output qword_t            push_data_o
);

  logic            accept;
  logic [QCNT_W:0] occ;
  logic [T_W-1:0]  spd_ext;
  logic [T_W-1:0]  prod;
  logic [T_W-1:0]  p_sum;
  logic [T_W-1:0]  t;
  logic [2:0]      code;
  shape_e          shp;
  logic            s1_valid_q;
  logic [T_W-1:0]  s1_p_q;

  assign occ        = (QCNT_W + 1)'(q_count_i) + (QCNT_W + 1)'(s1_valid_q);
  assign in_ready_o = occ < (QCNT_W + 1)'(QDEPTH);
  assign accept     = in_valid_i & in_ready_o;

  // Only the low 29 bits of the product survive the wrap.
  assign spd_ext = {{(T_W - 16){cfg_i.speed[15]}}, cfg_i.speed};
  assign prod    = spd_ext * beat_time_i[T_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_p_q <= prod;
    end
  end

  assign p_sum = s1_p_q + {cfg_i.phase[T_W-17:0], 16'h0000};

  always_comb begin
    if (cfg_i.mode[PINGPONG_BIT]) begin
      if (p_sum <= T_W'(29'h1000_0000)) t = p_sum;
      else                             t = ~p_sum + T_W'(1);
    end else begin
      t = {1'b0, p_sum[T_W-2:0]};
    end
  end

  assign code = cfg_i.mode[2:0];

  always_comb begin
    unique case (code) inside
      SHAPE_LINE, SHAPE_FIG8, SHAPE_HELIX, SHAPE_SPIRAL, SHAPE_LISSA: begin
        shp = shape_e'(code);
      end
      default: shp = SHAPE_CIRCLE;
    endcase
  end

  assign push_o            = s1_valid_q;
  assign push_data_o.t     = t;
  assign push_data_o.shape = shp;

endmodule

FILE: rtl/core/pppg_fifo.sv
// Short queue between front and back end.
// Depends on pppg_pkg.
module pppg_fifo
  import pppg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qword_t            push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output qword_t            data_o,
  output logic [QCNT_W-1:0] count_o
);

  qword_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wptr_q;
  logic [QPTR_W-1:0]  rptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               do_pop;

  assign valid_o = count_q != '0;
  assign do_pop  = pop_i & valid_o;
  assign data_o  = mem_q[rptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + QPTR_W'(1);
      if (do_pop) rptr_q <= rptr_q + QPTR_W'(1);
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/pppg_norm_div.sv
// Pipelined restoring divider for one normalized axis, one quotient bit a stage.
// Depends on pppg_pkg.
module pppg_norm_div
  import pppg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [COORD_W-1:0] coord_i,
  input  logic [15:0]               msize_i,
  output logic [NORM_W-1:0]         norm_o
);

  logic [16:0]       dvs;
  logic signed [17:0] s_sum;
  logic [16:0]       r_q   [NORM_W+1];
  logic [NORM_W-1:0] q_q   [NORM_W+1];
  logic              neg_q [NORM_W+1];
  logic              ovf_q [NORM_W+1];

  assign dvs   = {msize_i, 1'b0};
  assign s_sum = 18'(coord_i) + $signed({2'b00, msize_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= s_sum[16:0];
      q_q[0]   <= '0;
      neg_q[0] <= s_sum[17];
      ovf_q[0] <= !s_sum[17] && (s_sum[16:0] >= dvs);
      for (int j = 1; j <= NORM_W; j++) begin
        logic [17:0] tr;
        logic        ge;
        tr = {r_q[j-1], msize_i[NORM_W-j]};
        ge = tr >= {1'b0, dvs};
        r_q[j]   <= ge ? 17'(tr - {1'b0, dvs}) : tr[16:0];
        q_q[j]   <= {q_q[j-1][NORM_W-2:0], ge};
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign norm_o = neg_q[NORM_W] ? '0 : (ovf_q[NORM_W] ? '1 : q_q[NORM_W]);

endmodule

FILE: rtl/core/pppg_back.sv
// Back end: phases, sine table, per-axis products, rounding and normalizing.
// Depends on pppg_pkg and pppg_norm_div.
module pppg_back
  import pppg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      q_valid_i,
  input  qword_t                    q_data_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] point_x_o,
  output logic signed [COORD_W-1:0] point_y_o,
  output logic signed [COORD_W-1:0] point_z_o,
  output logic [PROG_W-1:0]         progress_o,
  output logic [NORM_W-1:0]         norm_x_o,
  output logic [NORM_W-1:0]         norm_y_o,
  output logic [NORM_W-1:0]         norm_z_o
);

  localparam int TB    = SINE_TABLE_BITS;
  localparam int PB    = PHASE_BITS;
  localparam int TAB_N = 1 << TB;
  localparam int NSTG  = 5 + DIV_LAT + 1;
  localparam int VW    = 60;
  localparam logic [PB-1:0] QUARTER = PB'(1) << (PB - 2);

  typedef struct packed {
    logic [TB:0] addr;
    logic        neg;
  } rom_rd_t;

  function automatic rom_rd_t sin_addr(input logic [PB-1:0] ph);
    logic [1:0]         quad;
    logic [PB+TB-3:0]   wide;
    logic [TB-1:0]      idx;
    rom_rd_t            r;
    quad   = ph[PB-1 -: 2];
    wide   = {ph[PB-3:0], {TB{1'b0}}} >> (PB - 2);
    idx    = wide[TB-1:0];
    r.addr = quad[0] ? ((TB + 1)'(TAB_N) - {1'b0, idx}) : {1'b0, idx};
    r.neg  = quad[1];
    return r;
  endfunction

  function automatic logic signed [13:0] apply_sign(input logic [SIN_W-1:0] v,
                                                    input logic neg);
    logic signed [13:0] s;
    s = $signed({1'b0, v});
    return neg ? -s : s;
  endfunction

  function automatic logic signed [COORD_W-1:0] rnd_sat(input logic signed [VW-1:0] v,
                                                        input logic [5:0] k);
    logic signed [VW-1:0] s;
    s = v + $signed(VW'(1) << (k - 6'd1));
    s = s >>> k;
    if (s < -VW'(65536))     return -17'sd65536;
    else if (s > VW'(65535)) return 17'sd65535;
    else                     return s[COORD_W-1:0];
  endfunction

  logic            en;
  logic [NSTG-1:0] vld_q;

  assign out_valid_o = vld_q[NSTG-1];
  assign en          = !out_valid_o || out_ready_i;
  assign q_pop_o     = en & q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], q_valid_i};
    end
  end

  logic [16:0] sx_s, sy_s, sz_s;
  assign sx_s = {1'b0, cfg_i.size_x};
  assign sy_s = {1'b0, cfg_i.size_y};
  assign sz_s = {1'b0, cfg_i.size_z};

  // B1: angle phases and 2t-1
  logic [7:0]            mul_a, mul_b;
  logic [44:0]           mt;
  logic [36:0]           ma, mb;
  logic [PB-1:0]         pa_d;
  logic signed [30:0]    lin_w;
  logic [T_W-1:0]        t1_q;
  shape_e                sh1_q;
  logic [PB-1:0]         pa1_q, pb1_q;
  logic signed [29:0]    lin1_q;

  assign mul_a = (cfg_i.ratio[7:0] == 8'd0) ? 8'd1 : cfg_i.ratio[7:0];
  assign mul_b = (cfg_i.ratio[15:8] == 8'd0) ? 8'd1 : cfg_i.ratio[15:8];
  assign mt    = 45'(q_data_i.t) * 45'(cfg_i.turns);
  assign ma    = 37'(q_data_i.t) * 37'(mul_a);
  assign mb    = 37'(q_data_i.t) * 37'(mul_b);
  assign lin_w = $signed({1'b0, q_data_i.t, 1'b0}) - 31'sd268435456;

  always_comb begin
    case (q_data_i.shape) inside
      SHAPE_HELIX, SHAPE_SPIRAL: pa_d = mt[40-PB +: PB];
      SHAPE_LISSA:               pa_d = ma[28-PB +: PB];
      default:                   pa_d = q_data_i.t[28-PB +: PB];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q   <= q_data_i.t;
      sh1_q  <= q_data_i.shape;
      pa1_q  <= pa_d;
      pb1_q  <= mb[28-PB +: PB];
      lin1_q <= lin_w[29:0];
    end
  end

  // B2: table reads and t times size products
  logic [SIN_W-1:0] rom [TAB_N+1];

  for (genvar gi = 0; gi <= TAB_N; gi++) begin : g_rom
    assign rom[gi] = sine_entry(gi, TB);
  end

  rom_rd_t rd_sa, rd_ca, rd_cb;
  assign rd_sa = sin_addr(pa1_q);
  assign rd_ca = sin_addr(pa1_q + QUARTER);
  assign rd_cb = sin_addr(pb1_q + QUARTER);

  logic [SIN_W-1:0]   sa2_q, ca2_q, cb2_q;
  logic               nsa2_q, nca2_q, ncb2_q;
  logic [44:0]        t2x_q, t2z_q;
  logic signed [29:0] lin2_q;
  shape_e             sh2_q;
  logic [PROG_W-1:0]  pg2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa2_q  <= rom[rd_sa.addr];
      ca2_q  <= rom[rd_ca.addr];
      cb2_q  <= rom[rd_cb.addr];
      nsa2_q <= rd_sa.neg;
      nca2_q <= rd_ca.neg;
      ncb2_q <= rd_cb.neg;
      t2x_q  <= 45'(t1_q) * 45'(cfg_i.size_x);
      t2z_q  <= 45'(t1_q) * 45'(cfg_i.size_z);
      lin2_q <= lin1_q;
      sh2_q  <= sh1_q;
      pg2_q  <= t1_q[T_W-1:12];
    end
  end

  // B3: trig and linear products
  logic signed [13:0] s_a, c_a, c_b;
  logic signed [13:0] vx, vy, vz;
  logic signed [45:0] ox, oz;
  logic signed [16:0] oy;

  assign s_a = apply_sign(sa2_q, nsa2_q);
  assign c_a = apply_sign(ca2_q, nca2_q);
  assign c_b = apply_sign(cb2_q, ncb2_q);

  always_comb begin
    vx = s_a;
    ox = $signed({29'd0, sx_s});
    vy = '0;
    oy = '0;
    vz = '0;
    oz = '0;
    case (sh2_q)
      SHAPE_CIRCLE: begin
        vx = c_a;
        vy = s_a;
        oy = sy_s;
      end
      SHAPE_FIG8: begin
        vy = s_a;
        oy = 17'(c_a);
      end
      SHAPE_HELIX: begin
        vx = c_a;
        vz = s_a;
        oz = $signed({29'd0, sz_s});
      end
      SHAPE_SPIRAL: begin
        vx = c_a;
        ox = $signed({1'b0, t2x_q});
        vz = s_a;
        oz = $signed({1'b0, t2z_q});
      end
      SHAPE_LISSA: begin
        vy = c_b;
        oy = sy_s;
        vz = c_a;
        oz = $signed({29'd0, sz_s});
      end
      default: ;
    endcase
  end

  logic signed [59:0] tx3_q, tz3_q;
  logic signed [30:0] ty3_q;
  logic signed [46:0] lx3_q, ly3_q, lz3_q;
  shape_e             sh3_q;
  logic [PROG_W-1:0]  pg3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx3_q <= 60'(vx) * 60'(ox);
      ty3_q <= 31'(vy) * 31'(oy);
      tz3_q <= 60'(vz) * 60'(oz);
      lx3_q <= 47'(lin2_q) * 47'($signed(sx_s));
      ly3_q <= 47'(lin2_q) * 47'($signed(sy_s));
      lz3_q <= 47'(lin2_q) * 47'($signed(sz_s));
      sh3_q <= sh2_q;
      pg3_q <= pg2_q;
    end
  end

  // B4: figure eight y product, per-shape selection
  logic signed [47:0]   ey;
  logic signed [VW-1:0] vx_d, vy_d, vz_d;
  logic [5:0]           kx_d, ky_d, kz_d;

  assign ey = 48'(ty3_q) * 48'($signed(sy_s));

  always_comb begin
    vx_d = tx3_q;
    kx_d = 6'd12;
    vy_d = VW'(ty3_q);
    ky_d = 6'd12;
    vz_d = tz3_q;
    kz_d = 6'd12;
    case (sh3_q)
      SHAPE_LINE: begin
        vx_d = VW'(lx3_q);
        kx_d = 6'd28;
        vy_d = VW'(ly3_q);
        ky_d = 6'd28;
        vz_d = VW'(lz3_q);
        kz_d = 6'd28;
      end
      SHAPE_FIG8: begin
        vy_d = VW'(ey);
        ky_d = 6'd24;
      end
      SHAPE_HELIX: begin
        vy_d = VW'(ly3_q);
        ky_d = 6'd28;
      end
      SHAPE_SPIRAL: begin
        kx_d = 6'd40;
        vy_d = VW'(ly3_q);
        ky_d = 6'd30;
        kz_d = 6'd40;
      end
      default: ;
    endcase
  end

  logic signed [VW-1:0] vx4_q, vy4_q, vz4_q;
  logic [5:0]           kx4_q, ky4_q, kz4_q;
  logic [PROG_W-1:0]    pg4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx4_q <= vx_d;
      vy4_q <= vy_d;
      vz4_q <= vz_d;
      kx4_q <= kx_d;
      ky4_q <= ky_d;
      kz4_q <= kz_d;
      pg4_q <= pg3_q;
    end
  end

  // B5: round half up, saturate
  coord_t c5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c5_q.x    <= rnd_sat(vx4_q, kx4_q);
      c5_q.y    <= rnd_sat(vy4_q, ky4_q);
      c5_q.z    <= rnd_sat(vz4_q, kz4_q);
      c5_q.prog <= pg4_q;
    end
  end

  // Normalizing divisor: largest size, at least MIN_SIZE
  logic [15:0] mxy, mxyz, msize;
  assign mxy   = (cfg_i.size_y > cfg_i.size_x) ? cfg_i.size_y : cfg_i.size_x;
  assign mxyz  = (cfg_i.size_z > mxy) ? cfg_i.size_z : mxy;
  assign msize = (mxyz < MIN_SIZE) ? MIN_SIZE : mxyz;

  logic [NORM_W-1:0] nx, ny, nz;

  pppg_norm_div u_div_x (.clk_i(clk_i), .en_i(en), .coord_i(c5_q.x), .msize_i(msize),
                         .norm_o(nx));
  pppg_norm_div u_div_y (.clk_i(clk_i), .en_i(en), .coord_i(c5_q.y), .msize_i(msize),
                         .norm_o(ny));
  pppg_norm_div u_div_z (.clk_i(clk_i), .en_i(en), .coord_i(c5_q.z), .msize_i(msize),
                         .norm_o(nz));

  coord_t dly_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= c5_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      point_x_o  <= dly_q[DIV_LAT-1].x;
      point_y_o  <= dly_q[DIV_LAT-1].y;
      point_z_o  <= dly_q[DIV_LAT-1].z;
      progress_o <= dly_q[DIV_LAT-1].prog;
      norm_x_o   <= nx;
      norm_y_o   <= ny;
      norm_z_o   <= nz;
    end
  end

endmodule

FILE: rtl/core/pppg_checker.sv
// Port-level checks for the parametric path point generator, bound to the top.
// Depends on pppg_pkg.
module pppg_checker
  import pppg_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [COORD_W-1:0] point_x_o,
  input logic signed [COORD_W-1:0] point_y_o,
  input logic signed [COORD_W-1:0] point_z_o,
  input logic [PROG_W-1:0]         progress_o,
  input logic [NORM_W-1:0]         norm_x_o,
  input logic [NORM_W-1:0]         norm_y_o,
  input logic [NORM_W-1:0]         norm_z_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(point_x_o) &&
    $stable(norm_x_o) && $stable(progress_o))
    else $error("stalled output word changed");

  a_prog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> progress_o <= 17'd65536)
    else $error("progress above one");

  a_norm_x_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> norm_x_o[NORM_W-1] == !point_x_o[COORD_W-1])
    else $error("norm_x on wrong side of one half");

  a_norm_yz_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (norm_y_o[NORM_W-1] == !point_y_o[COORD_W-1]) &&
    (norm_z_o[NORM_W-1] == !point_z_o[COORD_W-1]))
    else $error("norm_y or norm_z on wrong side of one half");

endmodule

bind parametric_path_point_generator pppg_checker u_pppg_checker (.*);
